// ===== design/magma_pkg.sv =====
// Shared types, constants and the pi substitution table for the Magma cipher core.
// No dependencies; imported by magma_round_cell and magma_block_cipher.
package magma_pkg;

    localparam int NumRounds = 32;
    localparam int KeyWords  = 8;
    localparam int WordW     = 32;
    localparam int KeyIdxW   = 3;
    localparam int CfgIdxW   = 4;
    localparam int RotLeft   = 11;
    localparam int RotRight  = 21;

    typedef logic [WordW-1:0]   t_word;
    typedef logic [KeyIdxW-1:0] t_key_idx;
    typedef logic [CfgIdxW-1:0] t_cfg_idx;

    // One item as it travels from cell to cell.
    typedef struct packed {
        logic  valid;
        logic  mode;
        t_word left;
        t_word right;
    } t_cell_bus;

    localparam logic [3:0] PiBox [KeyWords][16] = '{
        '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
          4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1},
        '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
          4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
        '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
          4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
        '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
          4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
        '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
          4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
        '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
          4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
        '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
          4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
        '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
          4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2}
    };

    // Key word used by each round.
    localparam t_key_idx OrderEnc [NumRounds] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
        3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0
    };

    localparam t_key_idx OrderDec [NumRounds] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
        3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0,
        3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0,
        3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0
    };

    function automatic logic [3:0] pi_sub(input t_key_idx box, input logic [3:0] nib);
        return PiBox[box][nib];
    endfunction

endpackage

// ===== design/magma_round_cell.sv =====
// One Feistel round of the Magma cipher, registered at its output.
// Depends on magma_pkg (types, pi table, rotation amounts).
module magma_round_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  magma_pkg::t_word     i_key_enc,
    input  magma_pkg::t_word     i_key_dec,
    input  magma_pkg::t_cell_bus i_bus,
    output magma_pkg::t_cell_bus o_bus
);
    import magma_pkg::*;

    t_word key;
    t_word sum;
    t_word subst;
    t_word n_right;

    logic  r_valid;
    logic  r_mode;
    t_word r_left;
    t_word r_right;

    always_comb begin
        key = i_bus.mode ? i_key_dec : i_key_enc;
        sum = i_bus.right + key;
        for (int n = 0; n < KeyWords; n++) begin
            subst[4*n +: 4] = pi_sub(t_key_idx'(n), sum[4*n +: 4]);
        end
        n_right = ((subst << RotLeft) | (subst >> RotRight)) ^ i_bus.left;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_bus.valid;
        end
        r_mode  <= i_bus.mode;
        r_left  <= i_bus.right;
        r_right <= n_right;
    end

    assign o_bus = '{valid: r_valid, mode: r_mode, left: r_left, right: r_right};

endmodule

// ===== design/magma_block_cipher.sv =====
// Top level of the Magma 64-bit block cipher: key registers and a chain of 32 round cells.
// Depends on magma_pkg and magma_round_cell.
//
//  channel   | ports                                         | handshake
//  ----------+-----------------------------------------------+---------------------------
//  command   | i_start, o_busy, i_mode, i_data_high/low      | taken when start && !busy
//  result    | o_done, o_result_high, o_result_low           | one-cycle strobe, no stall
//  key write | i_cfg_valid, o_cfg_ready, i_cfg_index/data    | taken when valid && ready
//
// Each round is one cell with its own register, so a block passes through the registers
// of all 32 cells on its way to its done strobe, and a new block can enter on every cycle.
// The chain holds the 32 rounds, one round per cell.
// busy stays low and the key port is always ready; keys should only change with
// no block in flight. Reset clears the key words and the valid bits of the chain.
// The result side has no back-pressure: a strobe is presented exactly once.
module magma_block_cipher (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic                i_mode,
    input  magma_pkg::t_word    i_data_high,
    input  magma_pkg::t_word    i_data_low,
    output logic                o_done,
    output magma_pkg::t_word    o_result_high,
    output magma_pkg::t_word    o_result_low,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  magma_pkg::t_cfg_idx i_cfg_index,
    input  magma_pkg::t_word    i_cfg_data
);
    import magma_pkg::*;

    t_word     r_key [KeyWords];
    t_cell_bus w_bus [NumRounds+1];
    logic      cfg_wr;

    // The chain never stalls, so neither side is ever held off.
    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // Key words; an index past the last word is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KeyWords; k++) begin
                r_key[k] <= '0;
            end
        end else if (cfg_wr && (i_cfg_index < t_cfg_idx'(KeyWords))) begin
            r_key[i_cfg_index[KeyIdxW-1:0]] <= i_cfg_data;
        end
    end

    assign w_bus[0] = '{valid: i_start && !o_busy, mode: i_mode,
                        left: i_data_high, right: i_data_low};

    // Each cell sees the two key words its round can use; the item's mode picks one.
    for (genvar g = 0; g < NumRounds; g++) begin : g_round
        magma_round_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_key_enc (r_key[OrderEnc[g]]),
            .i_key_dec (r_key[OrderDec[g]]),
            .i_bus     (w_bus[g]),
            .o_bus     (w_bus[g+1])
        );
    end

    // Last cell's registers drive the result; the final half swap is just wiring.
    assign o_done        = w_bus[NumRounds].valid;
    assign o_result_high = w_bus[NumRounds].right;
    assign o_result_low  = w_bus[NumRounds].left;

    // A done strobe always traces back to a block taken in at the head of the chain.
    a_done_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, NumRounds))
        else $error("done without a block taken 32 cycles earlier");

    // The mode travels with its block down the chain.
    a_mode_carried: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (w_bus[NumRounds].mode == $past(i_mode, NumRounds)))
        else $error("mode lost along the chain");

    // A key write with an index past the last word leaves the key words unchanged; words 0 and 7 are checked.
    a_bad_index_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && (i_cfg_index >= t_cfg_idx'(KeyWords))) |=>
            ($stable(r_key[0]) && $stable(r_key[7])))
        else $error("out-of-range key write changed a key word");

endmodule
